// ===== src/mtr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared types, constants and functions of the ranged random unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtr_pkg;

  localparam int STATE_WORDS = 624;
  localparam int TAP_OFFSET  = 397;
  localparam int IDX_W       = $clog2(STATE_WORDS);

  localparam logic [31:0] TWIST_MAT    = 32'h9908_b0df;
  localparam logic [31:0] HI_BIT       = 32'h8000_0000;
  localparam logic [31:0] LO_BITS      = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MUL     = 32'd1812433253;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;

  localparam logic [1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [1:0] MODE_SIGNED   = 2'd1;
  localparam logic [1:0] MODE_HIT      = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] lower_bound;
    logic [31:0] upper_bound;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        hit;
    logic [31:0] raw_word;
  } rsp_t;

  typedef struct packed {
    logic             shift;
    logic             seeding;
    logic [IDX_W-1:0] seed_idx;
  } chain_ctrl_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] t;
    t = x ^ (x >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

// ===== src/mt19937_ranged_random_unit.sv =====
// ----------------------------------------------------------------------------
// mt19937_ranged_random_unit
// MT19937 generator answering unsigned, signed and hit-test range requests.
// ----------------------------------------------------------------------------
// A request item on request is taken when start is high and busy is low.
// Each item yields one result on result, marked by done for one cycle; the
// receiver always takes it. The 624 state words live in a row of cells that
// shifts by one word per draw, so the twist is computed one word at a time
// at the tail of the row.
// A seeded draw keeps busy high for one cycle after the accept, so the next
// item can be taken as soon as busy falls; the result reaches the ports
// through the draw state, the drawn flag and the three mapping stages.
// After reset, and after every write of the seed register, the next item
// first reseeds the row, one word per cycle through the seeding multiplier,
// before that item's draw. The seed register resets to 5489.
// The seed is written through cfg_valid, cfg_ready and cfg_data; cfg_ready
// is high whenever no draw or seeding is in progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mt19937_ranged_random_unit import mtr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        done,
  output rsp_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEED = 3'b010,
    ST_DRAW = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] seed_idx;
  logic             seeded;
  logic [31:0]      seed;
  logic             drawn;
  req_t             req_q;
  logic             accept;
  logic             cfg_write;
  logic             seed_last;
  chain_ctrl_t      ctrl;
  logic [31:0]      tail;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = state == ST_IDLE;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign seed_last = seed_idx == IDX_W'(STATE_WORDS - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (seeded && !cfg_write) ? ST_DRAW : ST_SEED;
        end
      end
      ST_SEED: begin
        if (seed_last) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seeded   <= 1'b0;
      seed     <= DEFAULT_SEED;
      seed_idx <= '0;
      drawn    <= 1'b0;
    end else begin
      state <= state_next;
      drawn <= state == ST_DRAW;
      if (cfg_write) begin
        seed   <= cfg_data;
        seeded <= 1'b0;
      end else if (state == ST_SEED && seed_last) begin
        seeded <= 1'b1;
      end
      if (state == ST_SEED) begin
        seed_idx <= seed_idx + IDX_W'(1);
      end else begin
        seed_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
  end

  assign ctrl.shift    = state == ST_SEED || state == ST_DRAW;
  assign ctrl.seeding  = state == ST_SEED;
  assign ctrl.seed_idx = seed_idx;

  mtr_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .seed (seed),
    .tail (tail)
  );

  mtr_map u_map (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (drawn),
    .req       (req_q),
    .word      (tail),
    .out_valid (done),
    .out_rsp   (result)
  );

`ifndef SYNTHESIS
  a_draw_gives_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAW |-> ##4 done)
    else $error("draw did not produce a result four cycles later");

  a_seeded_accept_draws: assert property (@(posedge clk) disable iff (rst)
    accept && seeded && !cfg_write |=> state == ST_DRAW)
    else $error("seeded request did not go straight to a draw");

  a_cfg_clears_seeded: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !seeded)
    else $error("seed write did not force reseeding");

  a_seed_ends_in_draw: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEED && seed_last |=> state == ST_DRAW && seeded)
    else $error("seeding pass did not end in a seeded draw");

  a_no_done_while_seeding: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEED && $past(state) == ST_SEED |-> !done)
    else $error("result strobe during a seeding pass");
`endif

endmodule

// ===== src/mtr_cell.sv =====
// ----------------------------------------------------------------------------
// mtr_cell
// One state word of the generator; takes its neighbor's word on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtr_cell (
  input  logic        clk,
  input  logic        shift,
  input  logic [31:0] d,
  output logic [31:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== src/mtr_chain.sv =====
// ----------------------------------------------------------------------------
// mtr_chain
// Row of state cells with the seeding and twist feedback at its tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtr_chain import mtr_pkg::*; (
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  logic [31:0] seed,
  output logic [31:0] tail
);

  logic [31:0] words [STATE_WORDS];
  logic [31:0] feed;
  logic [31:0] mix;
  logic [31:0] twist_word;
  logic [31:0] seed_src;
  logic [31:0] seed_prod;
  logic [31:0] seed_word;

  always_comb begin
    mix        = (words[0] & HI_BIT) | (words[1] & LO_BITS);
    twist_word = words[TAP_OFFSET] ^ (mix >> 1) ^ (mix[0] ? TWIST_MAT : 32'd0);
    seed_src   = words[STATE_WORDS-1] ^ (words[STATE_WORDS-1] >> 30);
    seed_prod  = SEED_MUL * seed_src;
    seed_word  = seed_prod + 32'(ctrl.seed_idx);
    if (!ctrl.seeding) begin
      feed = twist_word;
    end else if (ctrl.seed_idx == '0) begin
      feed = seed;
    end else begin
      feed = seed_word;
    end
  end

  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
    if (i == STATE_WORDS - 1) begin : g_last
      mtr_cell u_cell (.clk(clk), .shift(ctrl.shift), .d(feed), .q(words[i]));
    end else begin : g_mid
      mtr_cell u_cell (.clk(clk), .shift(ctrl.shift), .d(words[i+1]), .q(words[i]));
    end
  end

  assign tail = words[STATE_WORDS-1];

endmodule

// ===== src/mtr_map.sv =====
// ----------------------------------------------------------------------------
// mtr_map
// Tempers a drawn word and maps it onto the requested range in three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtr_map import mtr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  req_t        req,
  input  logic [31:0] word,
  output logic        out_valid,
  output rsp_t        out_rsp
);

  logic [31:0] y;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [31:0] diff;
  logic        swap;

  logic        v1;
  logic [31:0] y1;
  logic [31:0] lo1;
  logic [31:0] span1;
  logic        full1;
  logic [1:0]  mode1;
  logic [31:0] prob1;

  logic [63:0] prod;
  logic        v2;
  logic [31:0] y2;
  logic [31:0] lo2;
  logic [31:0] off2;
  logic [1:0]  mode2;
  logic [31:0] prob2;

  logic [31:0] val;

  always_comb begin
    y    = temper(word);
    swap = 1'b0;
    lo   = 32'd0;
    hi   = 32'd0;
    case (req.mode)
      MODE_UNSIGNED: begin
        swap = req.lower_bound > req.upper_bound;
        lo   = swap ? req.upper_bound : req.lower_bound;
        hi   = swap ? req.lower_bound : req.upper_bound;
      end
      MODE_SIGNED: begin
        swap = (req.lower_bound ^ HI_BIT) > (req.upper_bound ^ HI_BIT);
        lo   = swap ? req.upper_bound : req.lower_bound;
        hi   = swap ? req.lower_bound : req.upper_bound;
      end
      MODE_HIT: begin
        swap = req.upper_bound == 32'd0;
        lo   = swap ? 32'd0 : 32'd1;
        hi   = swap ? 32'd1 : req.upper_bound;
      end
      default: begin
        swap = 1'b0;
      end
    endcase
    diff = hi - lo;
  end

  always_ff @(posedge clk) begin
    y1    <= y;
    lo1   <= lo;
    span1 <= diff + 32'd1;
    full1 <= &diff;
    mode1 <= req.mode;
    prob1 <= req.lower_bound;
  end

  assign prod = 64'(y1) * 64'(span1);

  always_ff @(posedge clk) begin
    y2    <= y1;
    lo2   <= lo1;
    off2  <= full1 ? y1 : prod[63:32];
    mode2 <= mode1;
    prob2 <= prob1;
  end

  assign val = lo2 + off2;

  always_ff @(posedge clk) begin
    out_rsp.raw_word <= y2;
    case (mode2)
      MODE_UNSIGNED, MODE_SIGNED: begin
        out_rsp.value <= val;
        out_rsp.hit   <= 1'b0;
      end
      MODE_HIT: begin
        out_rsp.value <= val;
        out_rsp.hit   <= val <= prob2;
      end
      default: begin
        out_rsp.value <= 32'd0;
        out_rsp.hit   <= 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ===== verif/tb_mt19937_ranged_random_unit.sv =====
// ----------------------------------------------------------------------------
// tb_mt19937_ranged_random_unit
// Self-checking testbench for the MT19937 ranged random unit.
// ----------------------------------------------------------------------------
// A local model of the generator is advanced on every accepted request. It
// seeds, twists and tempers its own copy of the 624 state words and maps each
// word to the unsigned, signed or hit-test result. Every strobed result is
// compared field by field with the oldest expected one. A short table of
// directed requests comes first. Random requests follow over several seed
// settings and sender idle rates. The seed is only rewritten once every
// result has come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mt19937_ranged_random_unit;
  import mtr_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] FIX_NONE  = 3'b000;
  localparam logic [2:0] FIX_VALUE = 3'b100;
  localparam logic [2:0] FIX_HIT   = 3'b010;
  localparam logic [2:0] FIX_RAW   = 3'b001;
  localparam logic [2:0] FIX_ALL   = 3'b111;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 8;
  localparam int DIR_ROWS     = 21;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] lower_bound;
    logic [31:0] upper_bound;
    logic [2:0]  fix;
    logic [31:0] value;
    logic        hit;
    logic [31:0] raw_word;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        done;
  rsp_t        result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  logic [31:0] mt_words [STATE_WORDS];
  int unsigned mt_pos;
  logic [31:0] seed_value;
  rsp_t        pending_results [$];
  int          error_count = 0;
  int          cycle_count = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{MODE_UNSIGNED, 32'h0000_0000, 32'hffff_ffff, FIX_ALL, 32'hd091_bb5c, 1'b0,
      32'hd091_bb5c},
    '{MODE_UNSIGNED, 32'h0000_0000, 32'hffff_ffff, FIX_ALL, 32'h22ae_9ef6, 1'b0,
      32'h22ae_9ef6},
    '{MODE_UNSIGNED, 32'h0000_0007, 32'h0000_0007, FIX_VALUE | FIX_HIT, 32'h7, 1'b0, 32'h0},
    '{MODE_UNSIGNED, 32'hffff_ffff, 32'hffff_ffff, FIX_VALUE | FIX_HIT, 32'hffff_ffff,
      1'b0, 32'h0},
    '{MODE_UNSIGNED, 32'h0000_0000, 32'h0000_0000, FIX_VALUE | FIX_HIT, 32'h0, 1'b0, 32'h0},
    '{MODE_UNSIGNED, 32'h0000_0100, 32'h0000_0010, FIX_NONE, 32'h0, 1'b0, 32'h0},
    '{MODE_UNSIGNED, 32'hffff_ffff, 32'h0000_0000, FIX_NONE, 32'h0, 1'b0, 32'h0},
    '{MODE_UNSIGNED, 32'h0000_0000, 32'h7fff_ffff, FIX_NONE, 32'h0, 1'b0, 32'h0},
    '{MODE_SIGNED, 32'h8000_0000, 32'h7fff_ffff, FIX_NONE, 32'h0, 1'b0, 32'h0},
    '{MODE_SIGNED, 32'h7fff_ffff, 32'h8000_0000, FIX_NONE, 32'h0, 1'b0, 32'h0},
    '{MODE_SIGNED, 32'hffff_fff6, 32'h0000_000a, FIX_NONE, 32'h0, 1'b0, 32'h0},
    '{MODE_SIGNED, 32'h0000_000a, 32'hffff_fff6, FIX_NONE, 32'h0, 1'b0, 32'h0},
    '{MODE_SIGNED, 32'h8000_0000, 32'h8000_0000, FIX_VALUE | FIX_HIT, 32'h8000_0000,
      1'b0, 32'h0},
    '{MODE_HIT, 32'h0000_0000, 32'h0000_0000, FIX_NONE, 32'h0, 1'b0, 32'h0},
    '{MODE_HIT, 32'h0000_0001, 32'h0000_0000, FIX_HIT, 32'h0, 1'b1, 32'h0},
    '{MODE_HIT, 32'hffff_ffff, 32'hffff_ffff, FIX_HIT, 32'h0, 1'b1, 32'h0},
    '{MODE_HIT, 32'h0000_0000, 32'h0000_0064, FIX_HIT, 32'h0, 1'b0, 32'h0},
    '{MODE_HIT, 32'h0000_0032, 32'h0000_0064, FIX_NONE, 32'h0, 1'b0, 32'h0},
    '{MODE_HIT, 32'h0000_0000, 32'h0000_0001, FIX_VALUE | FIX_HIT, 32'h1, 1'b0, 32'h0},
    '{MODE_UNUSED, 32'h1234_5678, 32'h9abc_def0, FIX_VALUE | FIX_HIT, 32'h0, 1'b0, 32'h0},
    '{MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff, FIX_VALUE | FIX_HIT, 32'h0, 1'b0, 32'h0}
  };

  mt19937_ranged_random_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void reseed_words(input logic [31:0] s);
    logic [31:0] p;
    mt_words[0] = s;
    for (int i = 1; i < STATE_WORDS; i++) begin
      p = mt_words[i - 1];
      mt_words[i] = SEED_MUL * (p ^ (p >> 30)) + 32'(i);
    end
  endfunction

  function automatic void twist_words();
    logic [31:0] y;
    logic [31:0] v;
    for (int k = 0; k < STATE_WORDS; k++) begin
      y = (mt_words[k] & HI_BIT) | (mt_words[(k + 1) % STATE_WORDS] & LO_BITS);
      v = mt_words[(k + TAP_OFFSET) % STATE_WORDS] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TWIST_MAT;
      end
      mt_words[k] = v;
    end
  endfunction

  function automatic logic [31:0] draw_word();
    logic [31:0] y;
    if (mt_pos >= STATE_WORDS) begin
      if (mt_pos != STATE_WORDS) begin
        reseed_words(seed_value);
      end
      twist_words();
      mt_pos = 0;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] scale_span(input logic [31:0] y, input logic [31:0] lo,
                                             input logic [31:0] hi);
    logic [32:0] span;
    logic [63:0] prod;
    span = {1'b0, hi - lo} + 33'd1;
    if (span[32]) begin
      return lo + y;
    end
    prod = {32'd0, y} * {31'd0, span};
    return lo + prod[63:32];
  endfunction

  function automatic rsp_t predict_draw(input req_t r);
    rsp_t o;
    logic [31:0] a;
    logic [31:0] b;
    a = r.lower_bound;
    b = r.upper_bound;
    o = '0;
    o.raw_word = draw_word();
    case (r.mode)
      MODE_UNSIGNED: begin
        o.value = (a > b) ? scale_span(o.raw_word, b, a) : scale_span(o.raw_word, a, b);
      end
      MODE_SIGNED: begin
        o.value = ((a ^ HI_BIT) > (b ^ HI_BIT)) ? scale_span(o.raw_word, b, a)
                                                : scale_span(o.raw_word, a, b);
      end
      MODE_HIT: begin
        o.value = (b < 32'd1) ? scale_span(o.raw_word, b, 32'd1)
                              : scale_span(o.raw_word, 32'd1, b);
        o.hit = (o.value <= a);
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic logic [31:0] edge_bound();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int pick;
    pick = $urandom_range(99);
    r.mode = (pick < 35) ? MODE_UNSIGNED : (pick < 70) ? MODE_SIGNED :
             (pick < 95) ? MODE_HIT : MODE_UNUSED;
    r.lower_bound = $urandom;
    case ($urandom_range(4))
      0: r.upper_bound = $urandom;
      1: r.upper_bound = r.lower_bound + $urandom_range(255);
      2: r.upper_bound = r.lower_bound;
      3: begin
        r.lower_bound = edge_bound();
        r.upper_bound = edge_bound();
      end
      default: r.upper_bound = r.lower_bound - $urandom_range(255);
    endcase
    if (r.mode == MODE_HIT) begin
      if ($urandom_range(3) == 0) begin
        r.upper_bound = $urandom_range(16);
      end
      if ($urandom_range(1) == 0) begin
        r.lower_bound = $urandom_range(r.upper_bound);
      end
    end
    return r;
  endfunction

  task automatic send_item(input req_t r, input int idle_pct, input logic [2:0] fix,
                           input rsp_t fixed);
    rsp_t want;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    want = predict_draw(r);
    if (fix[2]) want.value = fixed.value;
    if (fix[1]) want.hit = fixed.hit;
    if (fix[0]) want.raw_word = fixed.raw_word;
    pending_results.push_back(want);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_seed(input logic [31:0] s);
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= s;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    seed_value = s;
    mt_pos     = STATE_WORDS + 1;
  endtask

  task automatic run_draws(input int count, input int idle_pct);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 || $urandom_range(299) == 0) begin
        wait_drained();
      end
      send_item(random_request(), idle_pct, FIX_NONE, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %h hit %b raw_word %h",
               result.value, result.hit, result.raw_word);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, result.value);
          error_count++;
        end
        if (result.hit !== want.hit) begin
          $error("hit: expected %b, got %b", want.hit, result.hit);
          error_count++;
        end
        if (result.raw_word !== want.raw_word) begin
          $error("raw_word: expected %h, got %h", want.raw_word, result.raw_word);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    req_t r;
    rsp_t fixed;
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    seed_value = DEFAULT_SEED;
    mt_pos     = STATE_WORDS + 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      r.mode           = dir_rows[i].mode;
      r.lower_bound    = dir_rows[i].lower_bound;
      r.upper_bound    = dir_rows[i].upper_bound;
      fixed.value      = dir_rows[i].value;
      fixed.hit        = dir_rows[i].hit;
      fixed.raw_word   = dir_rows[i].raw_word;
      send_item(r, 0, dir_rows[i].fix, fixed);
    end
    run_draws(300, 0);

    write_seed(32'h0000_0000);
    run_draws(450, 70);
    write_seed(32'hffff_ffff);
    run_draws(450, 12);
    write_seed($urandom);
    run_draws(450, 0);
    write_seed(DEFAULT_SEED);
    run_draws(300, 70);

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
